@@ hdl/vlbp_pkg.sv @@
package vlbp_pkg;

  localparam int BYTE_W = 8;
  localparam int OP_W = 3;
  localparam int VALUE_W = 33;

  // Longest code: 2-bit tag plus a 32-bit body.
  localparam int CODE_W = 34;
  localparam int LEN_W = 6;
  // Up to 7 leftover bits plus one longest code.
  localparam int ACC_W = 41;
  localparam int CNT_W = 6;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_U8 = 3'd0;
  localparam logic [OP_W-1:0] OP_U16 = 3'd1;
  localparam logic [OP_W-1:0] OP_U32 = 3'd2;
  localparam logic [OP_W-1:0] OP_S16 = 3'd3;
  localparam logic [OP_W-1:0] OP_S32 = 3'd4;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd5;

  localparam logic [1:0] TAG_ZERO = 2'd0;
  localparam logic [1:0] TAG_SHORT = 2'd1;
  localparam logic [1:0] TAG_MID = 2'd2;
  localparam logic [1:0] TAG_FULL = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0] len;
    logic flush;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic flush;
    logic [CNT_W-1:0] cnt;
  } back_status_t;

endpackage

@@ hdl/vlbp_front.sv @@
module vlbp_front (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [vlbp_pkg::OP_W-1:0]        in_op,
  input  logic signed [vlbp_pkg::VALUE_W-1:0] in_value,
  output logic                             push,
  output vlbp_pkg::entry_t                 push_entry,
  input  logic                             push_ready
);

  logic [7:0] v8;
  logic [15:0] v16;
  logic [31:0] v32;
  logic keep;
  vlbp_pkg::entry_t ent;

  assign v8 = in_value[7:0];
  assign v16 = in_value[15:0];
  assign v32 = in_value[31:0];

  always_comb begin
    keep = 1'b1;
    ent.code = '0;
    ent.len = '0;
    ent.flush = 1'b0;
    unique case (in_op)
      vlbp_pkg::OP_U8: begin
        if (v8 == 8'd0) begin
          ent.len = vlbp_pkg::LEN_W'(1);
        end else if (v8[7:4] == 4'd0) begin
          ent.code = vlbp_pkg::CODE_W'({v8[3:0], vlbp_pkg::TAG_SHORT});
          ent.len = vlbp_pkg::LEN_W'(6);
        end else begin
          ent.code = vlbp_pkg::CODE_W'({v8, vlbp_pkg::TAG_FULL});
          ent.len = vlbp_pkg::LEN_W'(10);
        end
      end
      vlbp_pkg::OP_U16: begin
        if (v16 == 16'd0) begin
          ent.code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
          ent.len = vlbp_pkg::LEN_W'(2);
        end else if (v16[15:5] == '0) begin
          ent.code = vlbp_pkg::CODE_W'({v16[4:0], vlbp_pkg::TAG_SHORT});
          ent.len = vlbp_pkg::LEN_W'(7);
        end else if (v16[15:8] == '0) begin
          ent.code = vlbp_pkg::CODE_W'({v16[7:0], vlbp_pkg::TAG_MID});
          ent.len = vlbp_pkg::LEN_W'(10);
        end else begin
          ent.code = vlbp_pkg::CODE_W'({v16, vlbp_pkg::TAG_FULL});
          ent.len = vlbp_pkg::LEN_W'(18);
        end
      end
      vlbp_pkg::OP_U32: begin
        if (v32 == 32'd0) begin
          ent.code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
          ent.len = vlbp_pkg::LEN_W'(2);
        end else if (v32[31:6] == '0) begin
          ent.code = vlbp_pkg::CODE_W'({v32[5:0], vlbp_pkg::TAG_SHORT});
          ent.len = vlbp_pkg::LEN_W'(8);
        end else if (v32[31:11] == '0) begin
          ent.code = vlbp_pkg::CODE_W'({v32[10:0], vlbp_pkg::TAG_MID});
          ent.len = vlbp_pkg::LEN_W'(13);
        end else begin
          ent.code = {v32, vlbp_pkg::TAG_FULL};
          ent.len = vlbp_pkg::LEN_W'(34);
        end
      end
      vlbp_pkg::OP_S16: begin
        // Adding the bias to a value in range just inverts the range's top bit.
        if (v16 == 16'd0) begin
          ent.code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
          ent.len = vlbp_pkg::LEN_W'(2);
        end else if (v16[15:4] == '0 || v16[15:4] == '1) begin
          ent.code = vlbp_pkg::CODE_W'({~v16[4], v16[3:0], vlbp_pkg::TAG_SHORT});
          ent.len = vlbp_pkg::LEN_W'(7);
        end else if (v16[15:7] == '0 || v16[15:7] == '1) begin
          ent.code = vlbp_pkg::CODE_W'({~v16[7], v16[6:0], vlbp_pkg::TAG_MID});
          ent.len = vlbp_pkg::LEN_W'(10);
        end else begin
          ent.code = vlbp_pkg::CODE_W'({~v16[15], v16[14:0], vlbp_pkg::TAG_FULL});
          ent.len = vlbp_pkg::LEN_W'(18);
        end
      end
      vlbp_pkg::OP_S32: begin
        if (v32 == 32'd0) begin
          ent.code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
          ent.len = vlbp_pkg::LEN_W'(2);
        end else if (v32[31:5] == '0 || v32[31:5] == '1) begin
          ent.code = vlbp_pkg::CODE_W'({~v32[5], v32[4:0], vlbp_pkg::TAG_SHORT});
          ent.len = vlbp_pkg::LEN_W'(8);
        end else if (v32[31:10] == '0 || v32[31:10] == '1) begin
          ent.code = vlbp_pkg::CODE_W'({~v32[10], v32[9:0], vlbp_pkg::TAG_MID});
          ent.len = vlbp_pkg::LEN_W'(13);
        end else begin
          ent.code = {~v32[31], v32[30:0], vlbp_pkg::TAG_FULL};
          ent.len = vlbp_pkg::LEN_W'(34);
        end
      end
      vlbp_pkg::OP_FLUSH: begin
        ent.flush = 1'b1;
      end
      default: begin
        // Unused op codes are taken and dropped.
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = push_ready;
  assign push = in_valid && push_ready && keep;
  assign push_entry = ent;

endmodule

@@ hdl/vlbp_queue.sv @@
module vlbp_queue #(
  parameter int DEPTH = vlbp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vlbp_pkg::entry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output vlbp_pkg::entry_t pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vlbp_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hdl/vlbp_back.sv @@
module vlbp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  vlbp_pkg::entry_t             q_entry,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vlbp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last_of_run,
  output logic                         out_end_of_packet,
  output vlbp_pkg::back_status_t       status
);

  localparam int ACC_W = vlbp_pkg::ACC_W;
  localparam int CNT_W = vlbp_pkg::CNT_W;
  localparam int BYTE_W = vlbp_pkg::BYTE_W;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic flush_r, flush_nxt;
  logic out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic out_last_r;
  logic out_eop_r;

  logic can_adv, emit, full, last;
  logic [CNT_W-1:0] rem;
  logic [ACC_W-1:0] base_acc, new_acc;
  logic [CNT_W-1:0] base_cnt, new_cnt;
  logic free;

  assign can_adv = !out_valid_r || out_ready;
  assign emit = busy_r && can_adv;
  assign full = (cnt_r >= CNT_W'(BYTE_W));
  assign rem = cnt_r - CNT_W'(BYTE_W);
  // A partial byte only goes out on a flush, and it always ends the packet.
  assign last = full ? ((rem < CNT_W'(BYTE_W)) && !(flush_r && rem != '0)) : 1'b1;

  always_comb begin
    base_acc = acc_r;
    base_cnt = cnt_r;
    if (emit) begin
      base_acc = full ? (acc_r >> BYTE_W) : '0;
      base_cnt = full ? rem : '0;
    end
  end

  assign free = !busy_r || (emit && last);
  assign q_pop = free && q_valid;

  // The leftover is under one byte whenever a new code is merged in.
  assign new_acc = base_acc | (ACC_W'(q_entry.code) << base_cnt[2:0]);
  assign new_cnt = base_cnt + q_entry.len;

  always_comb begin
    acc_nxt = base_acc;
    cnt_nxt = base_cnt;
    flush_nxt = flush_r;
    busy_nxt = busy_r && !(emit && last);
    if (q_pop) begin
      acc_nxt = new_acc;
      cnt_nxt = new_cnt;
      flush_nxt = q_entry.flush;
      busy_nxt = (new_cnt >= CNT_W'(BYTE_W)) || (q_entry.flush && new_cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      busy_r <= 1'b0;
      flush_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      flush_r <= flush_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= acc_r[BYTE_W-1:0];
      out_last_r <= last;
      out_eop_r <= !full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_end_of_packet = out_eop_r;

  assign status.busy = busy_r;
  assign status.flush = flush_r;
  assign status.cnt = cnt_r;

endmodule

@@ hdl/varlen_integer_bit_packer_core.sv @@
// Packs typed integers (u8, u16, u32, s16, s32) into an LSB-first bit stream,
// each as a 2-bit size tag and a short, medium or full body (a zero as the tag
// alone, a u8 zero as a single 0 bit), delivered one byte per transaction; a
// flush item pads the last partial byte with zeros and flags it as the end of
// the packet. The input side encodes an item in the cycle it is accepted and
// parks it in a small queue, so items can be taken on consecutive cycles until
// the queue fills. The byte assembler drains the queue, taking the next item
// as it emits the last of the 0-5 bytes an item completes; the single-byte
// output port sets the sustained rate. Unused op codes are taken and dropped.
module varlen_integer_bit_packer_core #(
  parameter int QUEUE_DEPTH = vlbp_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vlbp_pkg::OP_W-1:0]           in_op,
  input  logic signed [vlbp_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vlbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_last_of_run,
  output logic                                out_end_of_packet
);

  logic push, push_ready;
  vlbp_pkg::entry_t push_entry;
  logic q_pop, q_valid;
  vlbp_pkg::entry_t q_entry;
  vlbp_pkg::back_status_t bst;

  vlbp_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_value   (in_value),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  vlbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  vlbp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_packet (out_end_of_packet),
    .status            (bst)
  );

`ifndef NO_ASSERTIONS
  // A padded end-of-packet byte always closes the run of its flush.
  a_eop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_packet |-> out_last_of_run)
    else $error("end-of-packet byte without last_of_run");

  // With no item in progress, less than one byte is left over.
  a_idle_leftover: assert property (@(posedge clk) disable iff (!rst_n)
    !bst.busy |-> bst.cnt < vlbp_pkg::CNT_W'(vlbp_pkg::BYTE_W))
    else $error("assembler idle with a whole byte pending");

  // An item in progress always has a byte left to deliver.
  a_busy_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    bst.busy |-> (bst.cnt >= vlbp_pkg::CNT_W'(vlbp_pkg::BYTE_W)) ||
                 (bst.flush && bst.cnt != '0))
    else $error("assembler busy with nothing to deliver");
`endif

endmodule

@@ tb/varlen_integer_bit_packer_core_tb.sv @@
module varlen_integer_bit_packer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 230;
  localparam int MAX_PRINTED = 100;

  // Op codes the block does not use.
  localparam logic [vlbp_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [vlbp_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [vlbp_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic                        eop;
  } packed_byte_t;

  // Tracks the bit stream the packer should produce and checks each output byte against it.
  class packer_scoreboard;
    logic [6:0]   pend_bits = '0;
    int           pend_cnt = 0;
    packed_byte_t byte_q[$];
    int           mismatches = 0;

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    // Builds the tag and body of one item, tag in the low bits, unused upper bits zero.
    function void build_code(input logic [vlbp_pkg::OP_W-1:0] op,
                             input logic signed [vlbp_pkg::VALUE_W-1:0] value,
                             output logic [vlbp_pkg::CODE_W-1:0] code, output int len);
      logic [7:0]          v8;
      logic [15:0]         v16;
      logic [31:0]         v32;
      logic signed [15:0]  s16v;
      logic signed [31:0]  s32v;
      longint              sv;
      longint              biased;
      code = '0;
      len = 0;
      v8 = value[7:0];
      v16 = value[15:0];
      v32 = value[31:0];
      s16v = value[15:0];
      s32v = value[31:0];
      case (op)
        vlbp_pkg::OP_U8: begin
          if (v8 == 8'd0) begin
            len = 1;
          end else if (v8[7:4] == 4'd0) begin
            code = vlbp_pkg::CODE_W'({v8[3:0], vlbp_pkg::TAG_SHORT});
            len = 6;
          end else begin
            code = vlbp_pkg::CODE_W'({v8, vlbp_pkg::TAG_FULL});
            len = 10;
          end
        end
        vlbp_pkg::OP_U16: begin
          if (v16 == 16'd0) begin
            code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
            len = 2;
          end else if (v16 < 16'h20) begin
            code = vlbp_pkg::CODE_W'({v16[4:0], vlbp_pkg::TAG_SHORT});
            len = 7;
          end else if (v16 < 16'h100) begin
            code = vlbp_pkg::CODE_W'({v16[7:0], vlbp_pkg::TAG_MID});
            len = 10;
          end else begin
            code = vlbp_pkg::CODE_W'({v16, vlbp_pkg::TAG_FULL});
            len = 18;
          end
        end
        vlbp_pkg::OP_U32: begin
          if (v32 == 32'd0) begin
            code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
            len = 2;
          end else if (v32 < 32'h40) begin
            code = vlbp_pkg::CODE_W'({v32[5:0], vlbp_pkg::TAG_SHORT});
            len = 8;
          end else if (v32 < 32'h800) begin
            code = vlbp_pkg::CODE_W'({v32[10:0], vlbp_pkg::TAG_MID});
            len = 13;
          end else begin
            code = {v32, vlbp_pkg::TAG_FULL};
            len = 34;
          end
        end
        vlbp_pkg::OP_S16: begin
          sv = longint'(s16v);
          if (sv == 0) begin
            code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
            len = 2;
          end else if (sv >= -16 && sv < 16) begin
            biased = sv + 16;
            code = vlbp_pkg::CODE_W'({biased[4:0], vlbp_pkg::TAG_SHORT});
            len = 7;
          end else if (sv >= -128 && sv < 128) begin
            biased = sv + 128;
            code = vlbp_pkg::CODE_W'({biased[7:0], vlbp_pkg::TAG_MID});
            len = 10;
          end else begin
            code = vlbp_pkg::CODE_W'({v16 ^ 16'h8000, vlbp_pkg::TAG_FULL});
            len = 18;
          end
        end
        vlbp_pkg::OP_S32: begin
          sv = longint'(s32v);
          if (sv == 0) begin
            code = vlbp_pkg::CODE_W'(vlbp_pkg::TAG_ZERO);
            len = 2;
          end else if (sv >= -32 && sv < 32) begin
            biased = sv + 32;
            code = vlbp_pkg::CODE_W'({biased[5:0], vlbp_pkg::TAG_SHORT});
            len = 8;
          end else if (sv >= -1024 && sv < 1024) begin
            biased = sv + 1024;
            code = vlbp_pkg::CODE_W'({biased[10:0], vlbp_pkg::TAG_MID});
            len = 13;
          end else begin
            code = {v32 ^ 32'h8000_0000, vlbp_pkg::TAG_FULL};
            len = 34;
          end
        end
        default: begin
          len = 0;
        end
      endcase
    endfunction

    function void note_item(input logic [vlbp_pkg::OP_W-1:0] op,
                            input logic signed [vlbp_pkg::VALUE_W-1:0] value);
      logic [vlbp_pkg::CODE_W-1:0] code;
      logic [63:0]                 acc;
      int                          len;
      int                          acc_len;
      int                          nfull;
      int                          total;
      bit                          pad;
      packed_byte_t                b;
      // Unused op codes leave the stream untouched.
      if (op > vlbp_pkg::OP_FLUSH) return;
      build_code(op, value, code, len);
      acc = {57'd0, pend_bits} | ({30'd0, code} << pend_cnt);
      acc_len = pend_cnt + len;
      nfull = acc_len / 8;
      pad = (op == vlbp_pkg::OP_FLUSH) && (acc_len % 8 != 0);
      total = nfull + int'(pad);
      for (int i = 0; i < total; i++) begin
        b.data = acc[7:0];
        b.last = (i == total - 1);
        b.eop = (i == nfull);
        byte_q.push_back(b);
        acc = acc >> 8;
      end
      if (pad) begin
        pend_bits = '0;
        pend_cnt = 0;
      end else begin
        pend_bits = acc[6:0];
        pend_cnt = acc_len - 8 * nfull;
      end
    endfunction

    task check_byte(input logic [vlbp_pkg::BYTE_W-1:0] data, input logic last,
                    input logic eop);
      packed_byte_t e;
      if (byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %b eop %b", data, last, eop));
        return;
      end
      e = byte_q.pop_front();
      if (data !== e.data) begin
        report_mismatch($sformatf("byte %02h, want %02h", data, e.data));
      end
      if (last !== e.last) begin
        report_mismatch($sformatf("last_of_run %b, want %b (byte %02h)", last, e.last, e.data));
      end
      if (eop !== e.eop) begin
        report_mismatch($sformatf("end_of_packet %b, want %b (byte %02h)", eop, e.eop, e.data));
      end
    endtask

    function int num_waiting();
      return byte_q.size();
    endfunction

    task flag_leftovers();
      foreach (byte_q[i]) begin
        report_mismatch($sformatf("byte %02h never came out", byte_q[i].data));
      end
      byte_q.delete();
    endtask
  endclass

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [vlbp_pkg::OP_W-1:0]           in_op = '0;
  logic signed [vlbp_pkg::VALUE_W-1:0] in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [vlbp_pkg::BYTE_W-1:0]         out_byte;
  logic                                out_last_of_run;
  logic                                out_end_of_packet;

  packer_scoreboard sb;
  bit               quiet_phase = 1'b0;
  int               stall_cycles = 0;

  varlen_integer_bit_packer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_packet(out_end_of_packet)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Entered right after a rising edge; returns at the edge where the transaction is taken.
  task send_item(input logic [vlbp_pkg::OP_W-1:0] op,
                 input logic signed [vlbp_pkg::VALUE_W-1:0] value);
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, value);
  endtask

  task idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Spreads values over every size class, negative ones included.
  function automatic logic signed [vlbp_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    int          k;
    logic [vlbp_pkg::VALUE_W-1:0] mag;
    r = $urandom();
    k = $urandom_range(0, 6);
    case (k)
      0: mag = '0;
      1: mag = vlbp_pkg::VALUE_W'($urandom_range(1, 16));
      2: mag = vlbp_pkg::VALUE_W'($urandom_range(17, 64));
      3: mag = vlbp_pkg::VALUE_W'($urandom_range(65, 2048));
      4: mag = {17'd0, r[15:0]};
      5: mag = {1'b0, r};
      default: mag = {2'b0, r[30:0]} + 33'd1;
    endcase
    if (k != 5 && $urandom_range(0, 1) == 1) return -$signed(mag);
    return $signed(mag);
  endfunction

  function automatic logic [vlbp_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    if (r < 14) return vlbp_pkg::OP_FLUSH;
    return vlbp_pkg::OP_W'($urandom_range(int'(vlbp_pkg::OP_U8), int'(vlbp_pkg::OP_S32)));
  endfunction

  // Result side back-pressure.
  initial begin
    repeat (11) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if (quiet_phase) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 24)) @(posedge clk);
        if (!quiet_phase && $urandom_range(0, 2) != 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_byte(out_byte, out_last_of_run, out_end_of_packet);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [vlbp_pkg::OP_W-1:0]           op;
    logic signed [vlbp_pkg::VALUE_W-1:0] value;
    int                                  n;
    sb = new;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Size boundaries of each type, truncation of wide values, flushes with and
    // without pending bits, and the unused op codes.
    send_item(vlbp_pkg::OP_U8, 33'sd0);
    send_item(vlbp_pkg::OP_U8, 33'sd15);
    send_item(vlbp_pkg::OP_U8, 33'sd16);
    send_item(vlbp_pkg::OP_U8, 33'sd255);
    send_item(vlbp_pkg::OP_U8, 33'sh1_0000_0100);
    send_item(vlbp_pkg::OP_FLUSH, 33'sd0);
    send_item(vlbp_pkg::OP_FLUSH, 33'sd0);
    send_item(vlbp_pkg::OP_U16, 33'sd31);
    send_item(vlbp_pkg::OP_U16, 33'sd32);
    send_item(vlbp_pkg::OP_U16, 33'sd256);
    send_item(vlbp_pkg::OP_U16, 33'sh0_0001_ffff);
    send_item(vlbp_pkg::OP_U32, 33'sd63);
    send_item(vlbp_pkg::OP_U32, 33'sd2048);
    send_item(vlbp_pkg::OP_U32, 33'sh0_ffff_ffff);
    send_item(vlbp_pkg::OP_S16, -33'sd16);
    send_item(vlbp_pkg::OP_S16, 33'sd15);
    send_item(vlbp_pkg::OP_S16, -33'sd129);
    send_item(vlbp_pkg::OP_S16, -33'sd32768);
    send_item(vlbp_pkg::OP_S32, 33'sd0);
    send_item(vlbp_pkg::OP_S32, -33'sd32);
    send_item(vlbp_pkg::OP_S32, 33'sd1023);
    send_item(vlbp_pkg::OP_S32, -33'sd2147483648);
    send_item(OP_SPARE_LO, 33'sh1_ffff_ffff);
    send_item(OP_SPARE_HI, 33'sd5);
    send_item(vlbp_pkg::OP_U16, 33'sd0);
    send_item(vlbp_pkg::OP_FLUSH, 33'sd0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      quiet_phase = (n >= 70 && n < 100) || n >= RANDOM_ITEMS - 40;
      if (n == 150) begin
        // Hold off until the packer has delivered everything owed so far.
        idle_for(1);
        while (sb.num_waiting() != 0) @(posedge clk);
      end
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 17));
      end
      op = pick_op();
      value = pick_value();
      send_item(op, value);
      if (op <= vlbp_pkg::OP_FLUSH) n++;
    end
    // Close the packet so every pending bit comes out.
    send_item(vlbp_pkg::OP_FLUSH, 33'sd0);
    in_valid <= 1'b0;

    while (sb.num_waiting() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
